// ===== hw/rtl/keyboard_backlight_controller_unit_defines.svh =====
// Assertion macros shared by the keyboard backlight controller RTL.
// Each macro expects clock aclk and active-low reset aresetn in scope.
`ifndef KEYBOARD_BACKLIGHT_CONTROLLER_UNIT_DEFINES_SVH
`define KEYBOARD_BACKLIGHT_CONTROLLER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KBLC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KBLC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/kblc_pkg.sv =====
// Shared types, command codes and constant tables for the keyboard backlight controller.
// No dependencies.
package kblc_pkg;

    typedef enum logic [3:0] {
        CMD_SET         = 4'd0,
        CMD_HOTKEY_SET  = 4'd1,
        CMD_TOGGLE      = 4'd2,
        CMD_INC         = 4'd3,
        CMD_DEC         = 4'd4,
        CMD_COLOR_CYCLE = 4'd5,
        CMD_REGION_SET  = 4'd6,
        CMD_REGION_READ = 4'd7,
        CMD_SUSPEND     = 4'd8,
        CMD_RESUME      = 4'd9
    } kblc_cmd_e;

    typedef struct packed {
        logic [3:0]  command;
        logic [7:0]  brightness_value;
        logic [1:0]  region;
        logic [23:0] color_rgb;
    } kblc_item_t;

    typedef struct packed {
        logic [31:0] ec_word;
        logic        word_valid;
        logic        changed_notice;
        logic [7:0]  brightness_now;
        logic [23:0] color_read;
        logic        last_of_run;
    } kblc_result_t;

    localparam logic [31:0] WORD_BRIGHT  = 32'hF400_0000;
    localparam logic [31:0] WORD_REGION0 = 32'hF000_0000;
    localparam logic [31:0] WORD_ENABLE  = 32'hE007_F001;
    localparam logic [31:0] WORD_DISABLE = 32'hE000_3001;

    localparam logic [7:0]  SAVED_RESET  = 8'd72;
    localparam logic [23:0] COLOR_WHITE  = 24'hFF_FFFF;
    localparam logic [2:0]  PALETTE_LAST = 3'd6;

    localparam int          LEVEL_COUNT  = 6;
    localparam logic [7:0]  LEVELS [LEVEL_COUNT] = '{8'd48, 8'd72, 8'd96, 8'd144, 8'd192, 8'd255};

    function automatic logic [23:0] palette_color(input logic [2:0] idx);
        logic [23:0] c;
        unique case (idx)
            3'd1:    c = 24'h00_00FF;
            3'd2:    c = 24'hFF_0000;
            3'd3:    c = 24'hFF_00FF;
            3'd4:    c = 24'h00_FF00;
            3'd5:    c = 24'h00_FFFF;
            3'd6:    c = 24'hFF_FF00;
            default: c = COLOR_WHITE;
        endcase
        return c;
    endfunction

    function automatic logic [31:0] bright_word(input logic [7:0] level);
        return WORD_BRIGHT | {24'd0, level};
    endfunction

    // The controller expects the color bytes ordered blue, red, green.
    function automatic logic [31:0] region_word(input logic [1:0] idx, input logic [23:0] rgb);
        return {WORD_REGION0[31:26], idx, rgb[7:0], rgb[23:16], rgb[15:8]};
    endfunction

endpackage

// ===== hw/rtl/kblc_engine.sv =====
// Item register, backlight state and per-result sequencing of the controller.
// Depends on kblc_pkg and keyboard_backlight_controller_unit_defines.svh.
`include "keyboard_backlight_controller_unit_defines.svh"

module kblc_engine import kblc_pkg::*; #(
    parameter int REGION_COUNT = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  kblc_item_t   in_item,
    input  logic         out_free,
    output logic         res_valid,
    output kblc_result_t res
);

    localparam int CODED  = (REGION_COUNT < 4) ? REGION_COUNT : 4;
    localparam int STEP_W = $clog2(CODED + 4);
    localparam int IDX_W  = (CODED > 1) ? $clog2(CODED) : 1;
    localparam logic [STEP_W-1:0] CODED_N  = STEP_W'(CODED);
    localparam logic [STEP_W-1:0] STEP_ONE = STEP_W'(1);

    logic              item_valid_reg;
    kblc_item_t        item_reg;
    logic [STEP_W-1:0] step_reg;
    logic [7:0]        brightness_reg;
    logic [7:0]        saved_reg;
    logic [2:0]        palette_reg;
    logic [23:0]       colors_reg [CODED];

    logic [STEP_W-1:0] n_res;
    logic [31:0]       word;
    logic              word_vld;
    logic [7:0]        new_bright;
    logic              bright_we;
    logic              save_we;
    logic              pal_we;
    logic              color_we;
    logic [1:0]        color_widx;
    logic [23:0]       color_wdata;
    logic [23:0]       color_rd;
    logic              notice_cmd;
    logic [1:0]        rd_idx;
    logic [23:0]       rd_data;
    logic              region_ok;
    logic [7:0]        up_level;
    logic              up_ok;
    logic [7:0]        down_level;
    logic              down_ok;
    logic [7:0]        tog_level;
    logic [2:0]        pal_next;
    logic [2:0]        cyc_idx;
    logic [1:0]        resume_ridx;
    logic              is_last;
    logic              has_out;
    logic              done;
    logic              accept;

    assign region_ok   = ({1'b0, item_reg.region} < 3'(CODED));
    assign tog_level   = (brightness_reg != 8'd0) ? 8'd0 : saved_reg;
    assign pal_next    = (palette_reg >= PALETTE_LAST) ? 3'd0 : palette_reg + 3'd1;
    // The palette advances on the first region word; later words reuse the stored index.
    assign cyc_idx     = (step_reg == '0) ? pal_next : palette_reg;
    assign resume_ridx = 2'(step_reg - STEP_ONE);
    assign rd_idx      = (item_reg.command == CMD_RESUME) ? resume_ridx : item_reg.region;
    assign rd_data     = colors_reg[rd_idx[IDX_W-1:0]];

    always_comb begin
        up_level   = 8'd0;
        up_ok      = 1'b0;
        down_level = 8'd0;
        down_ok    = 1'b0;
        for (int i = LEVEL_COUNT - 1; i >= 0; i--) begin
            if (LEVELS[i] > brightness_reg) begin
                up_level = LEVELS[i];
                up_ok    = 1'b1;
            end
        end
        for (int i = 0; i < LEVEL_COUNT; i++) begin
            if (LEVELS[i] < brightness_reg) begin
                down_level = LEVELS[i];
                down_ok    = 1'b1;
            end
        end
    end

    always_comb begin
        n_res       = '0;
        word        = '0;
        word_vld    = 1'b0;
        new_bright  = brightness_reg;
        bright_we   = 1'b0;
        save_we     = 1'b0;
        pal_we      = 1'b0;
        color_we    = 1'b0;
        color_widx  = item_reg.region;
        color_wdata = item_reg.color_rgb;
        color_rd    = '0;
        notice_cmd  = 1'b0;
        unique case (item_reg.command)
            CMD_SET, CMD_HOTKEY_SET: begin
                n_res      = STEP_ONE;
                new_bright = item_reg.brightness_value;
                bright_we  = 1'b1;
                notice_cmd = (item_reg.command == CMD_HOTKEY_SET);
            end
            CMD_TOGGLE: begin
                n_res      = STEP_ONE;
                new_bright = tog_level;
                save_we    = (brightness_reg != 8'd0);
                bright_we  = 1'b1;
                notice_cmd = 1'b1;
            end
            CMD_INC, CMD_DEC: begin
                notice_cmd = 1'b1;
                if (brightness_reg == 8'd0) begin
                    n_res      = STEP_ONE;
                    new_bright = tog_level;
                    bright_we  = 1'b1;
                end else if (item_reg.command == CMD_INC) begin
                    n_res      = up_ok ? STEP_ONE : '0;
                    new_bright = up_level;
                    bright_we  = 1'b1;
                end else begin
                    n_res      = down_ok ? STEP_ONE : '0;
                    new_bright = down_level;
                    bright_we  = 1'b1;
                end
            end
            CMD_COLOR_CYCLE: begin
                n_res       = CODED_N;
                notice_cmd  = 1'b1;
                pal_we      = (step_reg == '0);
                color_we    = 1'b1;
                color_widx  = 2'(step_reg);
                color_wdata = palette_color(cyc_idx);
                word        = region_word(color_widx, color_wdata);
                word_vld    = 1'b1;
            end
            CMD_REGION_SET: begin
                n_res    = region_ok ? STEP_ONE : '0;
                color_we = 1'b1;
                word     = region_word(item_reg.region, item_reg.color_rgb);
                word_vld = 1'b1;
            end
            CMD_REGION_READ: begin
                n_res    = STEP_ONE;
                color_rd = region_ok ? rd_data : '0;
            end
            CMD_SUSPEND: begin
                n_res    = STEP_ONE;
                word     = WORD_DISABLE;
                word_vld = 1'b1;
            end
            CMD_RESUME: begin
                // Disable, every coded region, brightness, then enable.
                n_res    = CODED_N + STEP_W'(3);
                word_vld = 1'b1;
                if (step_reg == '0) begin
                    word = WORD_DISABLE;
                end else if (step_reg <= CODED_N) begin
                    word = region_word(resume_ridx, rd_data);
                end else if (step_reg == CODED_N + STEP_ONE) begin
                    word      = bright_word(brightness_reg);
                    bright_we = 1'b1;
                end else begin
                    word = WORD_ENABLE;
                end
            end
            default: begin
                n_res = '0;
            end
        endcase
        if (bright_we) begin
            word     = bright_word(new_bright);
            word_vld = 1'b1;
        end
    end

    assign has_out   = (n_res != '0);
    assign is_last   = (step_reg == n_res - STEP_ONE);
    assign res_valid = item_valid_reg && has_out && out_free;
    assign done      = item_valid_reg && (!has_out || (out_free && is_last));
    assign in_ready  = !item_valid_reg || done;
    assign accept    = in_valid && in_ready;

    always_comb begin
        res.ec_word        = word;
        res.word_valid     = word_vld;
        res.changed_notice = notice_cmd && is_last;
        res.brightness_now = bright_we ? new_bright : brightness_reg;
        res.color_read     = color_rd;
        res.last_of_run    = is_last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            step_reg       <= '0;
            brightness_reg <= 8'd0;
            saved_reg      <= SAVED_RESET;
            palette_reg    <= 3'd0;
            for (int i = 0; i < CODED; i++) begin
                colors_reg[i] <= COLOR_WHITE;
            end
        end else begin
            if (accept) begin
                item_valid_reg <= 1'b1;
                step_reg       <= '0;
            end else if (done) begin
                item_valid_reg <= 1'b0;
                step_reg       <= '0;
            end else if (res_valid) begin
                step_reg <= step_reg + STEP_ONE;
            end
            if (res_valid) begin
                if (bright_we) begin
                    brightness_reg <= new_bright;
                end
                if (save_we) begin
                    saved_reg <= brightness_reg;
                end
                if (pal_we) begin
                    palette_reg <= pal_next;
                end
                if (color_we) begin
                    colors_reg[color_widx[IDX_W-1:0]] <= color_wdata;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= in_item;
        end
    end

    `KBLC_ASSERT_NEXT(a_accept_starts, accept, item_valid_reg && step_reg == '0,
                      "item not loaded at step zero")
    `KBLC_ASSERT_SAME(a_step_bound, item_valid_reg && has_out, step_reg < n_res,
                      "step beyond result count")
    `KBLC_ASSERT_NEXT(a_done_restart, done && !accept, !item_valid_reg && step_reg == '0,
                      "item not retired")

endmodule

// ===== hw/rtl/keyboard_backlight_controller_unit.sv =====
// Top level of the keyboard backlight controller: stream ports and the result register.
// Depends on kblc_pkg, kblc_engine and keyboard_backlight_controller_unit_defines.svh.
//
//  channel | dir | tdata fields (low bit up)                                | tuser / tlast
//  s_      | in  | brightness_value[7:0] region[9:8] color_rgb[33:10]       | tuser: command
//  m_      | out | ec_word[31:0] brightness_now[39:32] color_read[63:40]    | tuser: word_valid,
//          |     |                                                          | changed_notice; tlast
//
// An item enters the item register on acceptance; its results reach m_ via the result register.
// One result per cycle while m_tready allows: one for most commands, min(REGION_COUNT, 4) for
// color cycle and min(REGION_COUNT, 4) + 3 for resume; an item with no result retires unsent.
// The next item is taken in the cycle that the current item's last result is loaded.
// Reset leaves brightness 0, saved brightness 72, all regions white and palette position 0.
// A low m_tready holds the result register and stalls the engine and s_tready with it.
`include "keyboard_backlight_controller_unit_defines.svh"

module keyboard_backlight_controller_unit import kblc_pkg::*; #(
    parameter int REGION_COUNT = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // brightness_value, region, color_rgb, zero pad
    input  logic [3:0]  s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // ec_word, brightness_now, color_read
    output logic [1:0]  m_tuser,   // word_valid, changed_notice
    output logic        m_tlast
);

    kblc_item_t   in_item;
    kblc_result_t res;
    logic         res_valid;
    logic         out_free;
    logic         m_valid_reg;
    kblc_result_t m_res_reg;

    always_comb begin
        in_item.command          = s_tuser;
        in_item.brightness_value = s_tdata[7:0];
        in_item.region           = s_tdata[9:8];
        in_item.color_rgb        = s_tdata[33:10];
    end

    assign out_free = !m_valid_reg || m_tready;

    kblc_engine #(
        .REGION_COUNT(REGION_COUNT)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_res_reg.color_read, m_res_reg.brightness_now, m_res_reg.ec_word};
    assign m_tuser  = {m_res_reg.changed_notice, m_res_reg.word_valid};
    assign m_tlast  = m_res_reg.last_of_run;

    `KBLC_ASSERT_SAME(a_silent_word_zero, m_tvalid && !m_tuser[0], m_tdata[31:0] == 32'd0,
                      "word without send flag")
    `KBLC_ASSERT_SAME(a_notice_on_last, m_tvalid && m_tuser[1], m_tlast,
                      "change notice before last result")
    `KBLC_ASSERT_SAME(a_read_not_sent, m_tvalid && m_tdata[63:40] != 24'd0, !m_tuser[0],
                      "color read on a sent word")

endmodule

// ===== tb/keyboard_backlight_controller_unit_test.sv =====
// Self-checking stream testbench for keyboard_backlight_controller_unit.
// A built-in predictor checks every result transaction; depends only on kblc_pkg and the RTL.
module keyboard_backlight_controller_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import kblc_pkg::*;

    localparam int         RESET_CYCLES   = 8;
    localparam int         SETTLE_CYCLES  = 16;
    localparam int         STALL_LIMIT    = 2000;
    localparam int         CHUNKS         = 4;
    localparam int         CHUNK_ITEMS    = 103;
    localparam int         IDLE_PERCENT   = 15;
    localparam logic [3:0] CMD_FIRST_FREE = 4'd10;
    localparam logic [3:0] CMD_LAST_FREE  = 4'd15;

    localparam logic [7:0]  STEP_LEVELS [6] = '{8'd48, 8'd72, 8'd96, 8'd144, 8'd192, 8'd255};
    localparam logic [23:0] PALETTE [7] = '{24'hFFFFFF, 24'h0000FF, 24'hFF0000, 24'hFF00FF,
                                            24'h00FF00, 24'h00FFFF, 24'hFFFF00};

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;     // brightness_value, region, color_rgb, zero pad
    logic [3:0]  s_tuser  = '0;     // command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;           // ec_word, brightness_now, color_read
    logic [1:0]  m_tuser;           // word_valid, changed_notice
    logic        m_tlast;

    keyboard_backlight_controller_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    kblc_item_t   events_pending [$];
    kblc_item_t   event_on_bus;
    kblc_result_t ec_words_due [$];
    kblc_result_t event_words [$];
    logic         steady = 1'b0;
    int           mismatches = 0;
    int           quiet_cycles = 0;

    // Predictor copy of the controller state.
    logic [7:0]  level_now;
    logic [7:0]  level_saved;
    logic [23:0] region_rgb [4];
    logic [2:0]  palette_pos;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic void add_word(input logic [31:0] word, input logic valid,
                                     input logic [23:0] color);
        kblc_result_t r;
        r = '0;
        r.ec_word        = word;
        r.word_valid     = valid;
        r.brightness_now = level_now;
        r.color_read     = color;
        event_words.push_back(r);
    endfunction

    function automatic void send_level(input logic [7:0] level);
        level_now = level;
        add_word(WORD_BRIGHT | {24'd0, level}, 1'b1, 24'd0);
    endfunction

    // Region words carry the color bytes as blue, red, green.
    function automatic void send_region(input logic [1:0] idx, input logic [23:0] rgb);
        region_rgb[idx] = rgb;
        add_word(WORD_REGION0 | {6'd0, idx, 24'd0} | {8'd0, rgb[7:0], rgb[23:16], rgb[15:8]},
                 1'b1, 24'd0);
    endfunction

    function automatic void toggle_level();
        if (level_now != 8'd0) begin
            level_saved = level_now;
            send_level(8'd0);
        end else begin
            send_level(level_saved);
        end
    endfunction

    function automatic void predict_ec_words(input kblc_item_t ev);
        logic notice;
        logic found;
        notice = 1'b0;
        found  = 1'b0;
        event_words.delete();
        case (ev.command)
            CMD_SET: send_level(ev.brightness_value);
            CMD_HOTKEY_SET: begin
                send_level(ev.brightness_value);
                notice = 1'b1;
            end
            CMD_TOGGLE: begin
                toggle_level();
                notice = 1'b1;
            end
            CMD_INC: begin
                if (level_now == 8'd0) begin
                    toggle_level();
                end else begin
                    for (int i = 0; i < 6; i++) begin
                        if (!found && STEP_LEVELS[i] > level_now) begin
                            send_level(STEP_LEVELS[i]);
                            found = 1'b1;
                        end
                    end
                end
                notice = 1'b1;
            end
            CMD_DEC: begin
                if (level_now == 8'd0) begin
                    toggle_level();
                end else begin
                    for (int i = 5; i >= 0; i--) begin
                        if (!found && STEP_LEVELS[i] < level_now) begin
                            send_level(STEP_LEVELS[i]);
                            found = 1'b1;
                        end
                    end
                end
                notice = 1'b1;
            end
            CMD_COLOR_CYCLE: begin
                palette_pos = (palette_pos >= 3'd6) ? 3'd0 : palette_pos + 3'd1;
                for (int r = 0; r < 4; r++) send_region(r[1:0], PALETTE[palette_pos]);
                notice = 1'b1;
            end
            CMD_REGION_SET: send_region(ev.region, ev.color_rgb);
            CMD_REGION_READ: add_word(32'd0, 1'b0, region_rgb[ev.region]);
            CMD_SUSPEND: add_word(WORD_DISABLE, 1'b1, 24'd0);
            CMD_RESUME: begin
                add_word(WORD_DISABLE, 1'b1, 24'd0);
                for (int r = 0; r < 4; r++) send_region(r[1:0], region_rgb[r]);
                send_level(level_now);
                add_word(WORD_ENABLE, 1'b1, 24'd0);
            end
            default: ;
        endcase
        if (event_words.size() != 0) begin
            event_words[event_words.size() - 1].last_of_run    = 1'b1;
            event_words[event_words.size() - 1].changed_notice = notice;
        end
        foreach (event_words[i]) ec_words_due.push_back(event_words[i]);
    endfunction

    // Driver: presents queued events and predicts each one as it is accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid    <= 1'b0;
            s_tdata     <= '0;
            s_tuser     <= '0;
            level_now   = 8'd0;
            level_saved = SAVED_RESET;
            palette_pos = 3'd0;
            foreach (region_rgb[i]) region_rgb[i] = COLOR_WHITE;
        end else begin
            if (s_tvalid && s_tready) predict_ec_words(event_on_bus);
            if (!s_tvalid || s_tready) begin
                if (events_pending.size() != 0 &&
                    (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
                    event_on_bus = events_pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {6'd0, event_on_bus.color_rgb, event_on_bus.region,
                                 event_on_bus.brightness_value};
                    s_tuser  <= event_on_bus.command;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Monitor: compares each result transaction with the oldest predicted word.
    always @(posedge aclk) begin : result_monitor
        kblc_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (ec_words_due.size() == 0) begin
                    $error("unexpected result transaction, ec_word 0x%0h", m_tdata[31:0]);
                    mismatches++;
                end else begin
                    want = ec_words_due.pop_front();
                    check_field("ec_word", want.ec_word, m_tdata[31:0]);
                    check_field("word_valid", {31'd0, want.word_valid}, {31'd0, m_tuser[0]});
                    check_field("changed_notice", {31'd0, want.changed_notice},
                                {31'd0, m_tuser[1]});
                    check_field("brightness_now", {24'd0, want.brightness_now},
                                {24'd0, m_tdata[39:32]});
                    check_field("color_read", {8'd0, want.color_read}, {8'd0, m_tdata[63:40]});
                    check_field("last_of_run", {31'd0, want.last_of_run}, {31'd0, m_tlast});
                end
            end
            m_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    function automatic void queue_event(input logic [3:0] cmd, input logic [7:0] value,
                                        input logic [1:0] idx, input logic [23:0] rgb);
        kblc_item_t ev;
        ev.command          = cmd;
        ev.brightness_value = value;
        ev.region           = idx;
        ev.color_rgb        = rgb;
        events_pending.push_back(ev);
    endfunction

    // Returns 1 when the queued event is a real command.
    function automatic logic queue_random_event();
        int          pick;
        logic [3:0]  cmd;
        logic [7:0]  value;
        pick = $urandom_range(99);
        if      (pick < 10) cmd = CMD_SET;
        else if (pick < 20) cmd = CMD_HOTKEY_SET;
        else if (pick < 30) cmd = CMD_TOGGLE;
        else if (pick < 42) cmd = CMD_INC;
        else if (pick < 54) cmd = CMD_DEC;
        else if (pick < 62) cmd = CMD_COLOR_CYCLE;
        else if (pick < 74) cmd = CMD_REGION_SET;
        else if (pick < 84) cmd = CMD_REGION_READ;
        else if (pick < 89) cmd = CMD_SUSPEND;
        else if (pick < 95) cmd = CMD_RESUME;
        else                cmd = 4'($urandom_range(CMD_LAST_FREE, CMD_FIRST_FREE));
        // Table levels and their neighbors reach the stepping edge cases more often.
        pick = $urandom_range(99);
        if (pick < 35)      value = STEP_LEVELS[$urandom_range(5)];
        else if (pick < 50) value = STEP_LEVELS[$urandom_range(5)] + 8'($urandom_range(2)) - 8'd1;
        else if (pick < 65) value = $urandom_range(1) ? 8'd255 : 8'd0;
        else                value = 8'($urandom_range(255));
        queue_event(cmd, value, 2'($urandom_range(3)), 24'($urandom));
        return cmd < CMD_FIRST_FREE;
    endfunction

    // Holds further stimulus until the block has delivered every predicted word.
    task automatic drain_block();
        while (events_pending.size() != 0 || s_tvalid) @(negedge aclk);
        while (ec_words_due.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    initial begin
        int counted;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: level extremes, toggle save/restore, stepping ends, regions, power.
        queue_event(CMD_SET, 8'd255, 2'd0, 24'h000000);
        queue_event(CMD_SET, 8'd0, 2'd3, 24'hFFFFFF);
        queue_event(CMD_HOTKEY_SET, 8'hAA, 2'd1, 24'h5A5A5A);
        queue_event(CMD_TOGGLE, 8'd0, 2'd2, 24'hA5A5A5);
        queue_event(CMD_TOGGLE, 8'd0, 2'd0, 24'h000000);
        queue_event(CMD_SET, 8'd0, 2'd0, 24'h000000);
        queue_event(CMD_INC, 8'd0, 2'd0, 24'h000000);
        queue_event(CMD_SET, 8'd255, 2'd0, 24'h000000);
        queue_event(CMD_INC, 8'd0, 2'd0, 24'h000000);
        queue_event(CMD_SET, 8'd30, 2'd0, 24'h000000);
        queue_event(CMD_DEC, 8'd0, 2'd0, 24'h000000);
        queue_event(CMD_SET, 8'd50, 2'd0, 24'h000000);
        queue_event(CMD_INC, 8'd0, 2'd0, 24'h000000);
        queue_event(CMD_DEC, 8'd0, 2'd0, 24'h000000);
        queue_event(CMD_DEC, 8'd0, 2'd0, 24'h000000);
        queue_event(CMD_SET, 8'd0, 2'd0, 24'h000000);
        queue_event(CMD_DEC, 8'd0, 2'd0, 24'h000000);
        queue_event(CMD_COLOR_CYCLE, 8'd0, 2'd0, 24'h000000);
        queue_event(CMD_REGION_SET, 8'd0, 2'd0, 24'h123456);
        queue_event(CMD_REGION_SET, 8'd0, 2'd3, 24'hFEDCBA);
        queue_event(CMD_REGION_READ, 8'd0, 2'd0, 24'h000000);
        queue_event(CMD_REGION_READ, 8'd0, 2'd3, 24'h000000);
        queue_event(CMD_SUSPEND, 8'd0, 2'd0, 24'h000000);
        queue_event(CMD_RESUME, 8'd0, 2'd0, 24'h000000);
        queue_event(CMD_FIRST_FREE, 8'd0, 2'd0, 24'h000000);
        queue_event(CMD_LAST_FREE, 8'd0, 2'd0, 24'h000000);
        drain_block();

        // Random chunks, one of them without any idling; the block drains between chunks.
        for (int c = 0; c < CHUNKS; c++) begin
            steady = (c == 2);
            counted = 0;
            while (counted < CHUNK_ITEMS) begin
                if (queue_random_event()) counted++;
            end
            drain_block();
        end
        steady = 1'b0;

        if (ec_words_due.size() != 0) begin
            $error("%0d predicted words never arrived", ec_words_due.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
